FILE: sv/tpit_pkg.sv
// Shared types, codes and sizes for the timestamp pair interpolation table.
package tpit_pkg;

   // Table size and index widths
   localparam int MAX_PAIRS = 64;
   localparam int AW        = $clog2(MAX_PAIRS);
   localparam int CW        = $clog2(MAX_PAIRS + 1);
   localparam int TW        = 31;

   // Divider operand widths: dividend holds a product magnitude, divisor a time span
   localparam int DVD_W = 63;
   localparam int DVS_W = 31;

   // Operation codes
   localparam logic [2:0] MODE_ADD_FRAME = 3'd0;
   localparam logic [2:0] MODE_ADD_TIME  = 3'd1;
   localparam logic [2:0] MODE_REMOVE    = 3'd2;
   localparam logic [2:0] MODE_CLEAR     = 3'd3;
   localparam logic [2:0] MODE_V2D       = 3'd4;
   localparam logic [2:0] MODE_D2V       = 3'd5;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DUP       = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_BAD_INDEX = 3'd3;
   localparam logic [2:0] ST_NOT_READY = 3'd4;

   // One stored pair
   typedef struct packed {
      logic          flag;
      logic [TW-1:0] video;
      logic [TW-1:0] depth;
   } pair_type;

   localparam int PAIR_W = $bits(pair_type);

   // Divider handshake
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: sv/tpit_ram.sv
// Generic single write, single read RAM with registered read data.
module tpit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tpit_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module tpit_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tpit_pkg::div_req_type req,
   output tpit_pkg::div_rsp_type rsp
);
   import tpit_pkg::*;

   localparam int NW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;

   // One shift and trial subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = NW'(DVD_W);
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - NW'(1);
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

FILE: sv/timestamp_pair_interpolation_table.sv
// Top level: sorted pair table, sequencer and mapping datapath.
//
// Usage: one request carries mode, video_ms, depth_ms and entry_index; each
// request yields exactly one response (mapped_ms, status, pair_count,
// table_ready, time_based). Both channels use valid/ready.
// req_ready is high only while the sequencer is idle; one request is worked
// on at a time, all table access going through one single-port-read RAM.
// Work per request grows with the pairs held (the response turns valid as
// the sequencer returns to idle): clear, unused modes, a refused remove and
// a query when not ready go straight to the response; add scans every held
// pair, then moves the entries above the insert position up; remove moves
// the entries above the index down; a query reads the last entry, searches
// for its segment if needed and runs the divider (one quotient bit per
// cycle), but a single time-based pair is mapped directly.
// Reset empties the table at once (the pair count goes to zero; no clearing
// pass). A finished response waits in the output register while rsp_ready
// is low; a next request can still be taken, and its result waits until the
// held response is taken.
module timestamp_pair_interpolation_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [30:0]        req_video_ms,
   input  logic [30:0]        req_depth_ms,
   input  logic [5:0]         req_entry_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_mapped_ms,
   output logic [2:0]         rsp_status,
   output logic [6:0]         rsp_pair_count,
   output logic               rsp_table_ready,
   output logic               rsp_time_based
);
   import tpit_pkg::*;

   // Sequencer states
   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_SCAN_RD   = 5'd1;
   localparam logic [4:0] S_SCAN_CHK  = 5'd2;
   localparam logic [4:0] S_ADD_DEC   = 5'd3;
   localparam logic [4:0] S_SHIFT_RD  = 5'd4;
   localparam logic [4:0] S_SHIFT_WR  = 5'd5;
   localparam logic [4:0] S_INS       = 5'd6;
   localparam logic [4:0] S_RM_RD     = 5'd7;
   localparam logic [4:0] S_RM_WR     = 5'd8;
   localparam logic [4:0] S_RM_END    = 5'd9;
   localparam logic [4:0] S_Q_START   = 5'd10;
   localparam logic [4:0] S_Q_ONE     = 5'd11;
   localparam logic [4:0] S_Q_LAST    = 5'd12;
   localparam logic [4:0] S_Q_SRCH_RD = 5'd13;
   localparam logic [4:0] S_Q_SRCH_CK = 5'd14;
   localparam logic [4:0] S_Q_LO_RD   = 5'd15;
   localparam logic [4:0] S_Q_HI_RD   = 5'd16;
   localparam logic [4:0] S_Q_MUL     = 5'd17;
   localparam logic [4:0] S_Q_PREP    = 5'd18;
   localparam logic [4:0] S_Q_DIV     = 5'd19;
   localparam logic [4:0] S_Q_SUM     = 5'd20;
   localparam logic [4:0] S_Q_FIN     = 5'd21;
   localparam logic [4:0] S_DONE      = 5'd22;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   logic [4:0]          state_ff, state_in;
   logic [2:0]          mode_ff, mode_in;
   logic [TW-1:0]       video_ff, video_in;
   logic [TW-1:0]       depth_ff, depth_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                head_ff, head_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                dup_ff, dup_in;
   logic [2:0]          status_ff, status_in;
   logic signed [31:0]  mapped_ff, mapped_in;
   pair_type            lo_ff, lo_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic signed [31:0]  dd_ff, dd_in;
   logic [TW-1:0]       o0_ff, o0_in;
   logic                pneg_ff, pneg_in;
   logic                rnz_ff, rnz_in;
   logic signed [63:0]  acc_ff, acc_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_mapped_ff, rsp_mapped_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [CW-1:0]       rsp_count_ff, rsp_count_in;
   logic                rsp_ready_ff, rsp_ready_in;
   logic                rsp_tb_ff, rsp_tb_in;

   logic                ram_we;
   logic [CW-1:0]       ram_wa, ram_ra;
   pair_type            ram_wd, ram_rd;
   logic [PAIR_W-1:0]   ram_rd_bits;

   div_req_type         dreq;
   div_rsp_type         drsp;

   logic                is_query_v2d;
   logic [TW-1:0]       qx;
   logic [TW-1:0]       rd_key, rd_val, lo_key, lo_val;
   logic                tbl_ready, tbl_tb;
   logic signed [31:0]  dx, dy;
   logic signed [63:0]  pn, pmag;
   logic signed [31:0]  dpos;
   logic signed [63:0]  qext, s_adj;
   logic signed [33:0]  one_sum;

   // Key and value selection by query direction
   assign is_query_v2d = (mode_ff == MODE_V2D);
   assign qx     = is_query_v2d ? video_ff : depth_ff;
   assign rd_key = is_query_v2d ? ram_rd.video : ram_rd.depth;
   assign rd_val = is_query_v2d ? ram_rd.depth : ram_rd.video;
   assign lo_key = is_query_v2d ? lo_ff.video : lo_ff.depth;
   assign lo_val = is_query_v2d ? lo_ff.depth : lo_ff.video;

   assign tbl_tb    = (cnt_ff != '0) && head_ff;
   assign tbl_ready = tbl_tb || (cnt_ff > CW'(1));

   assign ram_rd = pair_type'(ram_rd_bits);

   // Main sequencer
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      video_in  = video_ff;
      depth_in  = depth_ff;
      cnt_in    = cnt_ff;
      head_in   = head_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      dup_in    = dup_ff;
      status_in = status_ff;
      mapped_in = mapped_ff;
      lo_in     = lo_ff;
      prod_in   = prod_ff;
      dd_in     = dd_ff;
      o0_in     = o0_ff;
      pneg_in   = pneg_ff;
      rnz_in    = rnz_ff;
      acc_in    = acc_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ready_in  = rsp_ready_ff;
      rsp_tb_in     = rsp_tb_ff;

      ram_we = 1'b0;
      ram_wa = ptr_ff;
      ram_wd = ram_rd;
      ram_ra = ptr_ff;

      dreq.start    = 1'b0;
      dreq.dividend = '0;
      dreq.divisor  = '0;

      dx      = $signed({1'b0, qx}) - $signed({1'b0, lo_key});
      dy      = $signed({1'b0, rd_val}) - $signed({1'b0, lo_val});
      pn      = (dd_ff < 0) ? -prod_ff : prod_ff;
      pmag    = pn[63] ? -pn : pn;
      dpos    = (dd_ff < 0) ? -dd_ff : dd_ff;
      qext    = $signed({1'b0, drsp.quotient});
      s_adj   = (rnz_ff && acc_ff < 0) ? acc_ff + 64'sd1 : acc_ff;
      one_sum = $signed({3'b000, rd_val}) - $signed({3'b000, rd_key})
              + $signed({3'b000, qx});

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               video_in  = req_video_ms;
               depth_in  = req_depth_ms;
               status_in = ST_OK;
               mapped_in = '0;
               ptr_in    = '0;
               pos_in    = '0;
               dup_in    = 1'b0;
               case (req_mode)
                  MODE_ADD_FRAME, MODE_ADD_TIME: begin
                     state_in = (cnt_ff == '0) ? S_ADD_DEC : S_SCAN_RD;
                  end
                  MODE_REMOVE: begin
                     ptr_in = CW'(req_entry_index);
                     if (CW'(req_entry_index) >= cnt_ff) begin
                        status_in = ST_BAD_INDEX;
                        state_in  = S_DONE;
                     end else if (CW'(req_entry_index) + CW'(1) < cnt_ff) begin
                        state_in = S_RM_RD;
                     end else begin
                        state_in = S_RM_END;
                     end
                  end
                  MODE_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_DONE;
                  end
                  MODE_V2D, MODE_D2V: begin
                     state_in = S_Q_START;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // Duplicate check and insert position over all held pairs
         S_SCAN_RD: begin
            ram_ra   = ptr_ff;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (ram_rd.video == video_ff || ram_rd.depth == depth_ff) begin
               dup_in = 1'b1;
            end
            if (ram_rd.video < video_ff) begin
               pos_in = pos_ff + CW'(1);
            end
            ptr_in   = ptr_ff + CW'(1);
            state_in = (ptr_ff + CW'(1) == cnt_ff) ? S_ADD_DEC : S_SCAN_RD;
         end
         S_ADD_DEC: begin
            ptr_in = cnt_ff;
            if (dup_ff) begin
               status_in = ST_DUP;
               state_in  = S_DONE;
            end else if (cnt_ff == CW'(MAX_PAIRS)) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else if (cnt_ff > pos_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_INS;
            end
         end

         // Open a slot: move entries up one place, top first
         S_SHIFT_RD: begin
            ram_ra   = ptr_ff - CW'(1);
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            ram_we   = 1'b1;
            ram_wa   = ptr_ff;
            ram_wd   = ram_rd;
            ptr_in   = ptr_ff - CW'(1);
            state_in = (ptr_ff - CW'(1) > pos_ff) ? S_SHIFT_RD : S_INS;
         end
         S_INS: begin
            ram_we       = 1'b1;
            ram_wa       = pos_ff;
            ram_wd.flag  = (mode_ff == MODE_ADD_TIME);
            ram_wd.video = video_ff;
            ram_wd.depth = depth_ff;
            if (pos_ff == '0) begin
               head_in = (mode_ff == MODE_ADD_TIME);
            end
            cnt_in   = cnt_ff + CW'(1);
            state_in = S_DONE;
         end

         // Close the gap: move entries down one place
         S_RM_RD: begin
            ram_ra   = ptr_ff + CW'(1);
            state_in = S_RM_WR;
         end
         S_RM_WR: begin
            ram_we = 1'b1;
            ram_wa = ptr_ff;
            ram_wd = ram_rd;
            if (ptr_ff == '0) begin
               head_in = ram_rd.flag;
            end
            ptr_in   = ptr_ff + CW'(1);
            state_in = (ptr_ff + CW'(2) < cnt_ff) ? S_RM_RD : S_RM_END;
         end
         S_RM_END: begin
            cnt_in   = cnt_ff - CW'(1);
            state_in = S_DONE;
         end

         // Query: pick the path and fetch the only or the last entry
         S_Q_START: begin
            if (!tbl_ready) begin
               status_in = ST_NOT_READY;
               state_in  = S_DONE;
            end else if (head_ff && cnt_ff == CW'(1)) begin
               ram_ra   = '0;
               state_in = S_Q_ONE;
            end else begin
               ram_ra   = cnt_ff - CW'(1);
               ptr_in   = cnt_ff - CW'(1);
               state_in = S_Q_LAST;
            end
         end
         S_Q_ONE: begin
            if (one_sum > 34'sd2147483647) begin
               mapped_in = 32'sh7fffffff;
            end else begin
               mapped_in = one_sum[31:0];
            end
            state_in = S_DONE;
         end
         S_Q_LAST: begin
            if (qx > rd_key) begin
               state_in = S_Q_LO_RD;
            end else begin
               ptr_in   = CW'(1);
               state_in = S_Q_SRCH_RD;
            end
         end
         S_Q_SRCH_RD: begin
            ram_ra   = ptr_ff;
            state_in = S_Q_SRCH_CK;
         end
         S_Q_SRCH_CK: begin
            if (ptr_ff < cnt_ff - CW'(1) && qx > rd_key) begin
               ptr_in   = ptr_ff + CW'(1);
               state_in = S_Q_SRCH_RD;
            end else begin
               state_in = S_Q_LO_RD;
            end
         end

         // Fetch the segment ends, lower then upper
         S_Q_LO_RD: begin
            ram_ra   = ptr_ff - CW'(1);
            state_in = S_Q_HI_RD;
         end
         S_Q_HI_RD: begin
            ram_ra   = ptr_ff;
            lo_in    = ram_rd;
            state_in = S_Q_MUL;
         end
         S_Q_MUL: begin
            prod_in  = dx * dy;
            dd_in    = $signed({1'b0, rd_key}) - $signed({1'b0, lo_key});
            o0_in    = lo_val;
            state_in = S_Q_PREP;
         end
         S_Q_PREP: begin
            if (dd_ff == '0) begin
               mapped_in = $signed({1'b0, o0_ff});
               state_in  = S_DONE;
            end else begin
               pneg_in       = pn[63];
               dreq.start    = 1'b1;
               dreq.dividend = pmag[DVD_W-1:0];
               dreq.divisor  = dpos[DVS_W-1:0];
               state_in      = S_Q_DIV;
            end
         end
         S_Q_DIV: begin
            if (drsp.done) begin
               rnz_in = (drsp.remainder != '0);
               if (pneg_ff) begin
                  acc_in = -qext - ((drsp.remainder != '0) ? 64'sd1 : 64'sd0);
               end else begin
                  acc_in = qext;
               end
               state_in = S_Q_SUM;
            end
         end
         S_Q_SUM: begin
            acc_in   = acc_ff + $signed({33'd0, o0_ff});
            state_in = S_Q_FIN;
         end
         S_Q_FIN: begin
            if (s_adj > SAT_MAX) begin
               mapped_in = 32'sh7fffffff;
            end else if (s_adj < SAT_MIN) begin
               mapped_in = 32'sh80000000;
            end else begin
               mapped_in = s_adj[31:0];
            end
            state_in = S_DONE;
         end

         // Hand the response to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_mapped_in = mapped_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = cnt_ff;
               rsp_ready_in  = tbl_ready;
               rsp_tb_in     = tbl_tb;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         head_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      video_ff      <= video_in;
      depth_ff      <= depth_in;
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      dup_ff        <= dup_in;
      status_ff     <= status_in;
      mapped_ff     <= mapped_in;
      lo_ff         <= lo_in;
      prod_ff       <= prod_in;
      dd_ff         <= dd_in;
      o0_ff         <= o0_in;
      pneg_ff       <= pneg_in;
      rnz_ff        <= rnz_in;
      acc_ff        <= acc_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ready_ff  <= rsp_ready_in;
      rsp_tb_ff     <= rsp_tb_in;
   end

   // Pair storage
   tpit_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (MAX_PAIRS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa[AW-1:0]),
      .wr_data (ram_wd),
      .rd_addr (ram_ra[AW-1:0]),
      .rd_data (ram_rd_bits)
   );

   // Serial divider
   tpit_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mapped_ms   = rsp_mapped_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pair_count  = rsp_count_ff;
   assign rsp_table_ready = rsp_ready_ff;
   assign rsp_time_based  = rsp_tb_ff;

endmodule

FILE: sv/tpit_chk.sv
// Port-level checker for the timestamp pair interpolation table, with its bind.
module tpit_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_mapped_ms,
   input logic [2:0]         rsp_status,
   input logic [6:0]         rsp_pair_count,
   input logic               rsp_table_ready,
   input logic               rsp_time_based
);
   import tpit_pkg::*;

   // A stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mapped_ms)
         && $stable(rsp_status) && $stable(rsp_pair_count))
      else $error("stalled response changed");

   // Count never exceeds capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pair_count <= 7'(MAX_PAIRS))
      else $error("pair count above capacity");

   // Readiness follows from count and time-based flag
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_table_ready == (rsp_pair_count > 7'd1
         || (rsp_pair_count == 7'd1 && rsp_time_based)))
      else $error("table ready flag inconsistent");

   // Not-ready answers carry no mapped time
   a_not_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOT_READY |-> rsp_mapped_ms == 32'sd0
         && !rsp_table_ready)
      else $error("not-ready response malformed");

   // Time-based flag needs a held pair
   a_tb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_time_based |-> rsp_pair_count != 7'd0)
      else $error("time based with empty table");

endmodule

bind timestamp_pair_interpolation_table tpit_chk u_tpit_chk (.*);
